### rtl/core/button_click_classifier_defines.svh
// Assertion macros for the RTL that checks itself.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BCC_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: implication");
// next-cycle implication
`define BCC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");
`else
`define BCC_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define BCC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

### rtl/core/bcc_pkg.sv
package bcc_pkg;

   localparam int EVENT_W     = 3;
   localparam int DEBOUNCE_W  = 10;
   localparam int LONG_W      = 16;
   localparam int GAP_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd3;
   localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd300;
   localparam logic [GAP_W-1:0]      GAP_RESET      = 8'd30;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 3'd0,
      EV_SINGLE = 3'd1,
      EV_DOUBLE = 3'd2,
      EV_TRIPLE = 3'd3,
      EV_LONG   = 3'd4
   } key_event_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_LONG     = 2'd1,
      CSR_GAP      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PRESS_IDLE     = 2'd0,
      PRESS_DEBOUNCE = 2'd1,
      PRESS_HELD     = 2'd2,
      PRESS_RELEASE  = 2'd3
   } press_phase_type;

   typedef enum logic [1:0] {
      CLICK_IDLE = 2'd0,
      CLICK_ONE  = 2'd1,
      CLICK_TWO  = 2'd2
   } click_phase_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [LONG_W-1:0]     long_press_ticks;
      logic [GAP_W-1:0]      click_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic down;
   } tick_type;

endpackage

### rtl/core/bcc_channels.sv
interface bcc_key_if;
   logic valid;
   logic ready;
   logic key_pressed;

   modport source (output valid, output key_pressed, input ready);
   modport sink   (input valid, input key_pressed, output ready);
endinterface

interface bcc_event_if;
   import bcc_pkg::*;
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] key_event;

   modport source (output valid, output key_event, input ready);
   modport sink   (input valid, input key_event, output ready);
endinterface

interface bcc_csr_if;
   import bcc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/bcc_csr_regs.sv
module bcc_csr_regs (
   input  logic         clock,
   input  logic         reset,
   bcc_csr_if.sink      csr_chan,
   output bcc_pkg::cfg_type cfg
);
   import bcc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks   = csr_chan.data[DEBOUNCE_W-1:0];
            CSR_LONG:     cfg_in.long_press_ticks = csr_chan.data[LONG_W-1:0];
            CSR_GAP:      cfg_in.click_gap_ticks  = csr_chan.data[GAP_W-1:0];
            // drop writes to unmapped indexes
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= LONG_RESET;
         cfg_ff.click_gap_ticks  <= GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/bcc_press_fsm.sv
module bcc_press_fsm (
   input  logic                         clock,
   input  logic                         reset,
   input  bcc_pkg::tick_type            tick,
   input  logic [bcc_pkg::DEBOUNCE_W-1:0] debounce_ticks,
   input  logic [bcc_pkg::LONG_W-1:0]     long_press_ticks,
   output bcc_pkg::key_event_type       press_event
);
   import bcc_pkg::*;

   press_phase_type       phase_ff;
   press_phase_type       phase_in;
   logic [LONG_W-1:0]     count_ff;
   logic [LONG_W-1:0]     count_in;
   logic [LONG_W-1:0]     count_inc;
   logic [LONG_W-1:0]     debounce_wide;

   // saturate at all ones
   assign count_inc     = (count_ff != {LONG_W{1'b1}}) ? count_ff + 1'b1 : count_ff;
   assign debounce_wide = {{(LONG_W-DEBOUNCE_W){1'b0}}, debounce_ticks};

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      press_event = EV_NONE;
      unique case (phase_ff)
         PRESS_IDLE: begin
            if (tick.down) begin
               count_in = '0;
               phase_in = PRESS_DEBOUNCE;
            end
         end
         PRESS_DEBOUNCE: begin
            if (tick.down) begin
               count_in = count_inc;
               if (count_inc >= debounce_wide) phase_in = PRESS_HELD;
            end else begin
               phase_in = PRESS_IDLE;
            end
         end
         PRESS_HELD: begin
            if (!tick.down) begin
               press_event = EV_SINGLE;
               phase_in    = PRESS_IDLE;
            end else begin
               count_in = count_inc;
               if (count_inc >= long_press_ticks) begin
                  press_event = EV_LONG;
                  phase_in    = PRESS_RELEASE;
               end
            end
         end
         PRESS_RELEASE: begin
            if (!tick.down) phase_in = PRESS_IDLE;
         end
         default: phase_in = PRESS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PRESS_IDLE;
         count_ff <= '0;
      end else if (tick.step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/bcc_click_fsm.sv
module bcc_click_fsm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  bcc_pkg::key_event_type       press_event,
   input  logic [bcc_pkg::GAP_W-1:0]    click_gap_ticks,
   output bcc_pkg::key_event_type       click_event
);
   import bcc_pkg::*;

   click_phase_type    phase_ff;
   click_phase_type    phase_in;
   logic [GAP_W-1:0]   gap_ff;
   logic [GAP_W-1:0]   gap_in;
   logic [GAP_W-1:0]   gap_inc;

   assign gap_inc = (gap_ff != {GAP_W{1'b1}}) ? gap_ff + 1'b1 : gap_ff;

   always_comb begin
      phase_in    = phase_ff;
      gap_in      = gap_ff;
      click_event = EV_NONE;
      unique case (phase_ff)
         CLICK_IDLE: begin
            if (press_event == EV_SINGLE) begin
               gap_in   = '0;
               phase_in = CLICK_ONE;
            end else begin
               click_event = press_event;
            end
         end
         CLICK_ONE, CLICK_TWO: begin
            if (press_event == EV_SINGLE) begin
               gap_in = '0;
               if (phase_ff == CLICK_ONE) begin
                  phase_in = CLICK_TWO;
               end else begin
                  click_event = EV_TRIPLE;
                  phase_in    = CLICK_IDLE;
               end
            end else begin
               // a long press here is dropped and counts as a gap tick
               gap_in = gap_inc;
               if (gap_inc >= click_gap_ticks) begin
                  click_event = (phase_ff == CLICK_ONE) ? EV_SINGLE : EV_DOUBLE;
                  phase_in    = CLICK_IDLE;
               end
            end
         end
         default: phase_in = CLICK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= CLICK_IDLE;
         gap_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         gap_ff   <= gap_in;
      end
   end

endmodule

### rtl/core/button_click_classifier.sv
// Button click classifier: takes one sampled key level per transaction and
// returns one event code per transaction (0 none, 1 single, 2 double,
// 3 triple, 4 long press). It sustains one transaction per clock cycle; a
// result passes through the input register and then the result register,
// with both state machines updating as the item leaves the input register.
// Backpressure on the result side stalls the input side only when both
// registers are full. Configuration writes are always accepted and should
// be issued while no transaction is in flight; writes to unmapped indexes
// are ignored.
`include "button_click_classifier_defines.svh"

module button_click_classifier (
   input logic        clock,
   input logic        reset,
   bcc_key_if.sink    req_chan,
   bcc_event_if.source rsp_chan,
   bcc_csr_if.sink    csr_chan
);
   import bcc_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   logic               in_key_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [EVENT_W-1:0] rsp_event_ff;
   logic               advance;
   logic               step;
   tick_type           tick;
   cfg_type            cfg;
   key_event_type      press_event;
   key_event_type      click_event;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) in_key_ff <= req_chan.key_pressed;
      if (step) rsp_event_ff <= click_event;
   end

   assign tick.step = step;
   assign tick.down = in_key_ff;

   bcc_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   bcc_press_fsm u_press (
      .clock            (clock),
      .reset            (reset),
      .tick             (tick),
      .debounce_ticks   (cfg.debounce_ticks),
      .long_press_ticks (cfg.long_press_ticks),
      .press_event      (press_event)
   );

   bcc_click_fsm u_click (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .press_event     (press_event),
      .click_gap_ticks (cfg.click_gap_ticks),
      .click_event     (click_event)
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.key_event = rsp_event_ff;

   `BCC_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step, rsp_valid_ff)
   `BCC_ASSERT_IMPLIES(a_rsp_has_source, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(in_valid_ff))
   `BCC_ASSERT_IMPLIES(a_triple_from_click, clock, reset, step && click_event == EV_TRIPLE, press_event == EV_SINGLE)

endmodule
